>>> src/moving_window_deconvolution_macros.svh
// ----------------------------------------------------------------------------
// moving window deconvolution assertion macros
// concurrent assertion wrappers, empty under synthesis
// ----------------------------------------------------------------------------
`ifndef MOVING_WINDOW_DECONVOLUTION_MACROS_SVH
`define MOVING_WINDOW_DECONVOLUTION_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define MWD_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mwd assertion failed");
// next-cycle implication
`define MWD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mwd assertion failed");
`else
`define MWD_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define MWD_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

>>> src/mwd_pkg.sv
// ----------------------------------------------------------------------------
// mwd_pkg
// shared widths and beat types of the moving window deconvolution
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mwd_pkg;

    localparam int ACC_BITS   = 48;
    localparam int SUM_BITS   = 58;
    localparam int DECAY_BITS = 17;

    // register indexes, byte address is four times the index
    typedef enum logic [1:0] {
        REG_DECAY  = 2'd0,
        REG_OFFSET = 2'd1,
        REG_WINDOW = 2'd2
    } t_reg_idx;

    typedef struct packed {
        logic                valid;
        logic [SUM_BITS-1:0] sum;
    } t_sum_beat;

    typedef struct packed {
        logic                valid;
        logic [ACC_BITS-1:0] filtered;
    } t_res_beat;

endpackage

>>> src/mwd_in_if.sv
// ----------------------------------------------------------------------------
// mwd_in_if
// sample stream channel, one sample and its first flag per beat
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface mwd_in_if #(
    parameter int SAMPLE_BITS = 16
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          first;

    modport source (output valid, output sample, output first, input ready);
    modport sink (input valid, input sample, input first, output ready);
endinterface

>>> src/mwd_out_if.sv
// ----------------------------------------------------------------------------
// mwd_out_if
// filtered result channel, one Q31.16 average per beat
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface mwd_out_if;
    import mwd_pkg::*;

    logic                       valid;
    logic                       ready;
    logic signed [ACC_BITS-1:0] filtered;

    modport source (output valid, output filtered, input ready);
    modport sink (input valid, input filtered, output ready);
endinterface

>>> src/mwd_core.sv
// ----------------------------------------------------------------------------
// mwd_core
// accumulator, offset differentiator and running window sum; both
// histories live in single-port-read synchronous memories
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "moving_window_deconvolution_macros.svh"

module mwd_core #(
    parameter int MAX_OFFSET  = 1024,
    parameter int MAX_WINDOW  = 1024,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_adv,
    input  logic                              i_valid,
    input  logic signed [SAMPLE_BITS-1:0]     i_sample,
    input  logic                              i_first,
    input  logic [mwd_pkg::DECAY_BITS-1:0]    i_decay,
    input  logic [$clog2(MAX_OFFSET+1)-1:0]   i_ofs,
    input  logic [$clog2(MAX_WINDOW+1)-1:0]   i_win,
    output mwd_pkg::t_sum_beat                o_sum
);
    import mwd_pkg::*;

    localparam int FRAC_BITS = 16;
    localparam int OFS_BITS  = $clog2(MAX_OFFSET + 1);
    localparam int WIN_BITS  = $clog2(MAX_WINDOW + 1);
    localparam int AA_BITS   = $clog2(MAX_OFFSET);
    localparam int DA_BITS   = $clog2(MAX_WINDOW);
    localparam int PA_BITS   = OFS_BITS + 1;
    localparam int PD_BITS   = WIN_BITS + 1;
    localparam int CNT_BITS  = $clog2(MAX_OFFSET + MAX_WINDOW + 1);
    localparam int CMP_BITS  = CNT_BITS + 1;
    localparam int PROD_BITS = SAMPLE_BITS + DECAY_BITS + 1;
    localparam int XPAD_BITS = ACC_BITS - SAMPLE_BITS - FRAC_BITS;

    typedef struct packed {
        logic clr;
        logic hasd;
        logic sub;
        logic emit;
    } t_flags;

    // running state
    logic signed [SAMPLE_BITS-1:0] r_prev;
    logic [CNT_BITS-1:0]           r_count;
    logic [AA_BITS-1:0]            r_awp;
    logic [DA_BITS-1:0]            r_dwp;
    logic [ACC_BITS-1:0]           r_acc;
    logic [SUM_BITS-1:0]           r_ws;

    // history memories
    logic [ACC_BITS-1:0] r_acc_mem [MAX_OFFSET];
    logic [ACC_BITS-1:0] r_dif_mem [MAX_WINDOW];
    logic [ACC_BITS-1:0] r_aq;
    logic [ACC_BITS-1:0] r_dq;
    logic                r_afwd;
    logic                r_dfwd;
    logic [ACC_BITS-1:0] r_dlast;

    // stage registers
    logic                          r_s1_v, r_s2_v, r_s3_v, r_s4_v, r_s5_v;
    t_flags                        r_s1_f, r_s2_f, r_s3_f, r_s4_f, r_s5_f;
    logic signed [SAMPLE_BITS-1:0] r_s1_x;
    logic signed [SAMPLE_BITS-1:0] r_s1_prev;
    logic [AA_BITS-1:0]            r_s1_awa, r_s2_awa, r_s3_awa;
    logic [AA_BITS-1:0]            r_s1_ara, r_s2_ara;
    logic [DA_BITS-1:0]            r_s1_dwa, r_s2_dwa, r_s3_dwa, r_s4_dwa, r_s5_dwa;
    logic [DA_BITS-1:0]            r_s1_dra, r_s2_dra, r_s3_dra, r_s4_dra;
    logic [ACC_BITS-1:0]           r_s2_xs, r_s3_xs;
    logic signed [PROD_BITS-1:0]   r_s2_prod, r_s3_prod;
    logic [ACC_BITS-1:0]           r_s4_acc, r_s4_hist;
    logic [ACC_BITS-1:0]           r_s5_d;
    logic                          r_sum_v;
    logic [SUM_BITS-1:0]           r_sum;

    logic                accept;
    logic [CNT_BITS-1:0] cur_idx;
    logic [CMP_BITS-1:0] idx_ext, ofs_ext, win_ext;
    logic [PA_BITS-1:0]  acc_tmp;
    logic [PD_BITS-1:0]  dif_tmp;
    t_flags              in_f;
    logic [ACC_BITS-1:0] acc_base, acc_next, prod_ext;
    logic [ACC_BITS-1:0] old_d;
    logic [SUM_BITS-1:0] ws_base, d_ext, old_ext, ws_next;

    assign accept = i_valid && i_adv;

    always_comb begin
        cur_idx = i_first ? '0 : r_count;
        idx_ext = CMP_BITS'(cur_idx);
        ofs_ext = CMP_BITS'(i_ofs);
        win_ext = CMP_BITS'(i_win);
        acc_tmp = PA_BITS'(r_awp) - PA_BITS'(i_ofs);
        if (acc_tmp[PA_BITS-1]) begin
            acc_tmp = acc_tmp + PA_BITS'(MAX_OFFSET);
        end
        dif_tmp = PD_BITS'(r_dwp) - PD_BITS'(i_win);
        if (dif_tmp[PD_BITS-1]) begin
            dif_tmp = dif_tmp + PD_BITS'(MAX_WINDOW);
        end
        in_f.clr  = i_first;
        in_f.hasd = idx_ext >= ofs_ext;
        in_f.sub  = idx_ext >= (ofs_ext + win_ext);
        in_f.emit = (idx_ext + CMP_BITS'(1)) >= (ofs_ext + win_ext);
    end

    always_comb begin
        acc_base = r_s3_f.clr ? '0 : r_acc;
        prod_ext = {{(ACC_BITS-PROD_BITS){r_s3_prod[PROD_BITS-1]}}, r_s3_prod};
        acc_next = acc_base + r_s3_xs - prod_ext;
        old_d    = r_dfwd ? r_dlast : r_dq;
        ws_base  = r_s5_f.clr ? '0 : r_ws;
        d_ext    = {{(SUM_BITS-ACC_BITS){r_s5_d[ACC_BITS-1]}}, r_s5_d};
        old_ext  = {{(SUM_BITS-ACC_BITS){old_d[ACC_BITS-1]}}, old_d};
        ws_next  = ws_base + d_ext - (r_s5_f.sub ? old_ext : '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev  <= '0;
            r_count <= '0;
            r_awp   <= '0;
            r_dwp   <= '0;
            r_acc   <= '0;
            r_ws    <= '0;
            r_s1_v  <= 1'b0;
            r_s2_v  <= 1'b0;
            r_s3_v  <= 1'b0;
            r_s4_v  <= 1'b0;
            r_s5_v  <= 1'b0;
            r_sum_v <= 1'b0;
        end else begin
            if (accept) begin
                r_prev <= i_sample;
                if (cur_idx < CNT_BITS'(MAX_OFFSET + MAX_WINDOW)) begin
                    r_count <= cur_idx + CNT_BITS'(1);
                end else begin
                    r_count <= cur_idx;
                end
                r_awp <= (r_awp == AA_BITS'(MAX_OFFSET - 1)) ? '0 : r_awp + AA_BITS'(1);
                if (in_f.hasd) begin
                    r_dwp <= (r_dwp == DA_BITS'(MAX_WINDOW - 1)) ? '0 : r_dwp + DA_BITS'(1);
                end
            end
            if (i_adv) begin
                r_s1_v  <= i_valid;
                r_s2_v  <= r_s1_v;
                r_s3_v  <= r_s2_v;
                r_s4_v  <= r_s3_v;
                r_s5_v  <= r_s4_v;
                r_sum_v <= r_s5_v && r_s5_f.emit;
                if (r_s3_v) begin
                    r_acc <= acc_next;
                end
                if (r_s5_v) begin
                    if (r_s5_f.hasd) begin
                        r_ws <= ws_next;
                    end else if (r_s5_f.clr) begin
                        r_ws <= '0;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_s1_x    <= i_sample;
            r_s1_prev <= i_first ? '0 : r_prev;
            r_s1_f    <= in_f;
            r_s1_awa  <= r_awp;
            r_s1_ara  <= acc_tmp[AA_BITS-1:0];
            r_s1_dwa  <= r_dwp;
            r_s1_dra  <= dif_tmp[DA_BITS-1:0];

            r_s2_xs   <= {{XPAD_BITS{r_s1_x[SAMPLE_BITS-1]}}, r_s1_x, {FRAC_BITS{1'b0}}};
            r_s2_prod <= r_s1_prev * $signed({1'b0, i_decay});
            r_s2_f    <= r_s1_f;
            r_s2_awa  <= r_s1_awa;
            r_s2_ara  <= r_s1_ara;
            r_s2_dwa  <= r_s1_dwa;
            r_s2_dra  <= r_s1_dra;

            r_s3_xs   <= r_s2_xs;
            r_s3_prod <= r_s2_prod;
            r_s3_f    <= r_s2_f;
            r_s3_awa  <= r_s2_awa;
            r_s3_dwa  <= r_s2_dwa;
            r_s3_dra  <= r_s2_dra;
            r_afwd    <= r_s3_v && (r_s3_awa == r_s2_ara);

            r_s4_acc  <= acc_next;
            r_s4_hist <= r_afwd ? r_acc : r_aq;
            r_s4_f    <= r_s3_f;
            r_s4_dwa  <= r_s3_dwa;
            r_s4_dra  <= r_s3_dra;

            r_s5_d    <= r_s4_acc - r_s4_hist;
            r_s5_f    <= r_s4_f;
            r_s5_dwa  <= r_s4_dwa;
            r_dfwd    <= r_s5_v && r_s5_f.hasd && (r_s5_dwa == r_s4_dra);

            r_sum     <= ws_next;
            if (r_s5_v && r_s5_f.hasd) begin
                r_dlast <= r_s5_d;
            end
        end
    end

    // accumulator history
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_aq <= r_acc_mem[r_s2_ara];
            if (r_s3_v) begin
                r_acc_mem[r_s3_awa] <= acc_next;
            end
        end
    end

    // difference history
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_dq <= r_dif_mem[r_s4_dra];
            if (r_s5_v && r_s5_f.hasd) begin
                r_dif_mem[r_s5_dwa] <= r_s5_d;
            end
        end
    end

    assign o_sum.valid = r_sum_v;
    assign o_sum.sum   = r_sum;

    `MWD_ASSERT_IMPL(a_emit_has_diff, i_clk, i_rst_n, r_s5_v && r_s5_f.emit, r_s5_f.hasd)
    `MWD_ASSERT_NEXT(a_first_restarts_count, i_clk, i_rst_n, accept && i_first, r_count == CNT_BITS'(1))
    `MWD_ASSERT_IMPL(a_ptr_range, i_clk, i_rst_n, 1'b1, (r_awp <= AA_BITS'(MAX_OFFSET - 1)) && (r_dwp <= DA_BITS'(MAX_WINDOW - 1)))

endmodule

>>> src/mwd_div.sv
// ----------------------------------------------------------------------------
// mwd_div
// pipelined signed divide of the window sum by the window length,
// truncating toward zero, four quotient bits per stage
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mwd_div #(
    parameter int MAX_WINDOW = 1024
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_adv,
    input  mwd_pkg::t_sum_beat              i_sum,
    input  logic [$clog2(MAX_WINDOW+1)-1:0] i_win,
    output mwd_pkg::t_res_beat              o_res
);
    import mwd_pkg::*;

    localparam int WIN_BITS  = $clog2(MAX_WINDOW + 1);
    localparam int STEP_BITS = 4;
    localparam int STAGES    = (SUM_BITS + STEP_BITS - 1) / STEP_BITS;
    localparam int DIV_BITS  = STAGES * STEP_BITS;

    logic                r_v   [STAGES+1];
    logic                r_neg [STAGES+1];
    logic [DIV_BITS-1:0] r_w   [STAGES+1];
    logic [WIN_BITS-1:0] r_rem [STAGES+1];
    logic                r_res_v;
    logic [ACC_BITS-1:0] r_res;

    logic [DIV_BITS-1:0] step_w   [STAGES];
    logic [WIN_BITS-1:0] step_rem [STAGES];
    logic [SUM_BITS-1:0] mag;
    logic [ACC_BITS-1:0] quo;

    function automatic logic [WIN_BITS+DIV_BITS-1:0] div_step(
        input logic [WIN_BITS-1:0] rem_in,
        input logic [DIV_BITS-1:0] w_in,
        input logic [WIN_BITS-1:0] len
    );
        logic [WIN_BITS:0]   t;
        logic [WIN_BITS-1:0] rem;
        logic [DIV_BITS-1:0] w;
        rem = rem_in;
        w   = w_in;
        for (int b = 0; b < STEP_BITS; b++) begin
            t = {rem, w[DIV_BITS-1]};
            w = {w[DIV_BITS-2:0], 1'b0};
            if (t >= {1'b0, len}) begin
                t    = t - {1'b0, len};
                w[0] = 1'b1;
            end
            rem = t[WIN_BITS-1:0];
        end
        return {rem, w};
    endfunction

    always_comb begin
        mag = i_sum.sum[SUM_BITS-1] ? (~i_sum.sum + SUM_BITS'(1)) : i_sum.sum;
        quo = r_w[STAGES][ACC_BITS-1:0];
        for (int k = 0; k < STAGES; k++) begin
            {step_rem[k], step_w[k]} = div_step(r_rem[k], r_w[k], i_win);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= STAGES; k++) begin
                r_v[k] <= 1'b0;
            end
            r_res_v <= 1'b0;
        end else if (i_adv) begin
            r_v[0] <= i_sum.valid;
            for (int k = 0; k < STAGES; k++) begin
                r_v[k+1] <= r_v[k];
            end
            r_res_v <= r_v[STAGES];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_neg[0] <= i_sum.sum[SUM_BITS-1];
            r_w[0]   <= DIV_BITS'(mag);
            r_rem[0] <= '0;
            for (int k = 0; k < STAGES; k++) begin
                r_neg[k+1] <= r_neg[k];
                r_w[k+1]   <= step_w[k];
                r_rem[k+1] <= step_rem[k];
            end
            r_res <= r_neg[STAGES] ? (~quo + ACC_BITS'(1)) : quo;
        end
    end

    assign o_res.valid    = r_res_v;
    assign o_res.filtered = r_res;

endmodule

>>> src/moving_window_deconvolution.sv
// ----------------------------------------------------------------------------
// moving_window_deconvolution
// Streaming moving window deconvolution filter. Takes one signed sample per
// clock while the output buffer has room and, once a waveform has delivered
// offset + window - 1 samples, gives one Q31.16 average per sample. A sample
// beat with first set starts a new waveform. A result passes through the
// accumulator, history memory and window sum pipeline, then through the
// divider stages at four quotient bits per stage of the 58-bit sum, into the
// output register. A two-entry output buffer lets input keep flowing while
// one result waits; the pipeline holds only once both entries are full. Both
// histories sit in memories with a registered read, so no reset sweep is
// needed. Registers (APB, 32-bit): 0x0 decay factor Q1.16,
// 0x4 differentiation offset, 0x8 window length; write them only while idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "moving_window_deconvolution_macros.svh"

module moving_window_deconvolution #(
    parameter int MAX_OFFSET  = 1024,
    parameter int MAX_WINDOW  = 1024,
    parameter int SAMPLE_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    mwd_in_if.sink      i_in,
    mwd_out_if.source   o_out,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import mwd_pkg::*;

    localparam int LEN_CFG_BITS = 11;
    localparam int OFS_BITS     = $clog2(MAX_OFFSET + 1);
    localparam int WIN_BITS     = $clog2(MAX_WINDOW + 1);

    localparam logic [DECAY_BITS-1:0] DECAY_RESET = DECAY_BITS'(65536);

    logic [DECAY_BITS-1:0]   r_decay;
    logic [LEN_CFG_BITS-1:0] r_offset;
    logic [LEN_CFG_BITS-1:0] r_window;

    logic                r_out_v;
    logic [ACC_BITS-1:0] r_out_data;
    logic                r_skid_v;
    logic [ACC_BITS-1:0] r_skid_data;

    logic                cfg_wr;
    logic                adv;
    logic [OFS_BITS-1:0] ofs;
    logic [WIN_BITS-1:0] win;
    t_sum_beat           sum_beat;
    t_res_beat           res_beat;

    assign cfg_wr = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_decay  <= DECAY_RESET;
            r_offset <= LEN_CFG_BITS'(1);
            r_window <= LEN_CFG_BITS'(1);
        end else if (cfg_wr) begin
            unique case (paddr[3:2])
                REG_DECAY:  r_decay  <= pwdata[DECAY_BITS-1:0];
                REG_OFFSET: r_offset <= pwdata[LEN_CFG_BITS-1:0];
                REG_WINDOW: r_window <= pwdata[LEN_CFG_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        unique case (paddr[3:2])
            REG_DECAY:  prdata = 32'(r_decay);
            REG_OFFSET: prdata = 32'(r_offset);
            REG_WINDOW: prdata = 32'(r_window);
            default:    prdata = '0;
        endcase
    end

    // zero means one, larger than the history means the history depth
    always_comb begin
        if (r_offset == '0) begin
            ofs = OFS_BITS'(1);
        end else if (32'(r_offset) > 32'(MAX_OFFSET)) begin
            ofs = OFS_BITS'(MAX_OFFSET);
        end else begin
            ofs = OFS_BITS'(r_offset);
        end
        if (r_window == '0) begin
            win = WIN_BITS'(1);
        end else if (32'(r_window) > 32'(MAX_WINDOW)) begin
            win = WIN_BITS'(MAX_WINDOW);
        end else begin
            win = WIN_BITS'(r_window);
        end
    end

    assign adv        = !r_skid_v;
    assign i_in.ready = adv;

    mwd_core #(
        .MAX_OFFSET  (MAX_OFFSET),
        .MAX_WINDOW  (MAX_WINDOW),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_adv    (adv),
        .i_valid  (i_in.valid),
        .i_sample (i_in.sample),
        .i_first  (i_in.first),
        .i_decay  (r_decay),
        .i_ofs    (ofs),
        .i_win    (win),
        .o_sum    (sum_beat)
    );

    mwd_div #(
        .MAX_WINDOW (MAX_WINDOW)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_sum   (sum_beat),
        .i_win   (win),
        .o_res   (res_beat)
    );

    // output register with one skid entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (!r_skid_v) begin
            if (res_beat.valid) begin
                if (!r_out_v || o_out.ready) begin
                    r_out_v <= 1'b1;
                end else begin
                    r_skid_v <= 1'b1;
                end
            end else if (o_out.ready) begin
                r_out_v <= 1'b0;
            end
        end else if (o_out.ready) begin
            r_skid_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_skid_v) begin
            if (res_beat.valid) begin
                if (!r_out_v || o_out.ready) begin
                    r_out_data <= res_beat.filtered;
                end else begin
                    r_skid_data <= res_beat.filtered;
                end
            end
        end else if (o_out.ready) begin
            r_out_data <= r_skid_data;
        end
    end

    assign o_out.valid    = r_out_v;
    assign o_out.filtered = r_out_data;

    `MWD_ASSERT_IMPL(a_skid_behind_out, i_clk, i_rst_n, r_skid_v, r_out_v)

endmodule
